// File: rtl/float32_magnitude_adder_assert.svh
// Assertion macros shared by the single-precision magnitude adder RTL.
// Depends on nothing; included by the top level only.
`ifndef FLOAT32_MAGNITUDE_ADDER_ASSERT_SVH
`define FLOAT32_MAGNITUDE_ADDER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define FMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/fma_pkg.sv
// Package for the single-precision magnitude adder: widths and stage payload types.
// Depends on nothing.
`default_nettype none
package fma_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned ExpW = 8;
    localparam int unsigned FracW = 23;
    localparam int unsigned SigW = 24;
    localparam int unsigned FrameW = 27;
    localparam int unsigned StageCount = 4;

    typedef struct packed {
        logic              sign;
        logic [ExpW-1:0]   exp_big;
        logic [ExpW-1:0]   shift_dist;
        logic [SigW-1:0]   big_sig;
        logic [SigW-1:0]   small_sig;
        logic              signs_differ;
    } align_t;

    typedef struct packed {
        logic              sign;
        logic [ExpW:0]     exp_big;
        logic [FrameW:0]   total;
        logic              signs_differ;
    } add_t;

    typedef struct packed {
        logic              sign;
        logic [ExpW:0]     exp_norm;
        logic [FrameW-1:0] total;
        logic              signs_differ;
    } norm_t;

    typedef struct packed {
        logic [WordW-1:0]  sum_bits;
        logic              signs_differ;
        logic              exponent_overflow;
    } result_t;
endpackage
`default_nettype wire

// File: rtl/fma_datapath.sv
// Four-stage datapath of the magnitude adder: compare/swap, align+add, normalize, round.
// Depends on fma_pkg; stage advance is driven by the top-level pipeline control.
`default_nettype none
module fma_datapath (
    input  wire logic                      clk,
    input  wire logic [fma_pkg::StageCount-1:0] advance,
    input  wire logic [fma_pkg::WordW-1:0] operand_a,
    input  wire logic [fma_pkg::WordW-1:0] operand_b,
    output fma_pkg::result_t               result
);
    import fma_pkg::*;

    align_t  s1_reg;
    add_t    s2_reg;
    norm_t   s3_reg;
    result_t s4_reg;
    align_t  s1_next;
    add_t    s2_next;
    norm_t   s3_next;
    result_t s4_next;

    logic [ExpW-1:0]   ea;
    logic [ExpW-1:0]   eb;
    logic              a_big;
    logic [FrameW-1:0] small27;
    logic [SigW-1:0]   shifted;
    logic [SigW-1:0]   lost_mask;
    logic [ExpW-1:0]   drop;
    logic [SigW-1:0]   sig;
    logic [SigW:0]     sig_r;
    logic [ExpW:0]     exp_r;
    logic              guard;

    always_comb
    begin
        ea = operand_a[WordW-2 -: ExpW];
        eb = operand_b[WordW-2 -: ExpW];
        a_big = (ea >= eb);
        s1_next.sign = a_big ? operand_a[WordW-1] : operand_b[WordW-1];
        s1_next.exp_big = a_big ? ea : eb;
        s1_next.shift_dist = a_big ? (ea - eb) : (eb - ea);
        s1_next.big_sig = {1'b1, a_big ? operand_a[FracW-1:0] : operand_b[FracW-1:0]};
        s1_next.small_sig = {1'b1, a_big ? operand_b[FracW-1:0] : operand_a[FracW-1:0]};
        s1_next.signs_differ = operand_a[WordW-1] ^ operand_b[WordW-1];
    end

    always_comb
    begin
        drop = s1_reg.shift_dist - ExpW'(2);
        shifted = s1_reg.small_sig >> drop;
        lost_mask = ~({SigW{1'b1}} << drop);
        if (s1_reg.shift_dist < ExpW'(3))
        begin
            small27 = FrameW'({s1_reg.small_sig, 3'b000} >> s1_reg.shift_dist);
        end
        else if (s1_reg.shift_dist < ExpW'(26))
        begin
            small27 = {2'b00, shifted, |(s1_reg.small_sig & lost_mask)};
        end
        else
        begin
            small27 = FrameW'(1);
        end
        s2_next.sign = s1_reg.sign;
        s2_next.exp_big = {1'b0, s1_reg.exp_big};
        s2_next.total = {1'b0, s1_reg.big_sig, 3'b000} + {1'b0, small27};
        s2_next.signs_differ = s1_reg.signs_differ;
    end

    always_comb
    begin
        s3_next.sign = s2_reg.sign;
        s3_next.signs_differ = s2_reg.signs_differ;
        if (s2_reg.total[FrameW])
        begin
            s3_next.total = {s2_reg.total[FrameW:2], |s2_reg.total[1:0]};
            s3_next.exp_norm = s2_reg.exp_big + (ExpW+1)'(1);
        end
        else
        begin
            s3_next.total = s2_reg.total[FrameW-1:0];
            s3_next.exp_norm = s2_reg.exp_big;
        end
    end

    always_comb
    begin
        sig = s3_reg.total[FrameW-1:3];
        guard = s3_reg.total[2];
        sig_r = {1'b0, sig} + (SigW+1)'(guard & ((|s3_reg.total[1:0]) | sig[0]));
        exp_r = s3_reg.exp_norm + (ExpW+1)'(sig_r[SigW]);
        s4_next.sum_bits = {s3_reg.sign, exp_r[ExpW-1:0],
                            sig_r[SigW] ? sig_r[FracW:1] : sig_r[FracW-1:0]};
        s4_next.signs_differ = s3_reg.signs_differ;
        s4_next.exponent_overflow = (exp_r >= (ExpW+1)'(255));
    end

    always_ff @(posedge clk)
    begin
        if (advance[0]) s1_reg <= s1_next;
        if (advance[1]) s2_reg <= s2_next;
        if (advance[2]) s3_reg <= s3_next;
        if (advance[3]) s4_reg <= s4_next;
    end

    assign result = s4_reg;
endmodule
`default_nettype wire

// File: rtl/float32_magnitude_adder.sv
// Top level of the single-precision magnitude adder: stream ports and pipeline control.
// Depends on fma_pkg, fma_datapath and float32_magnitude_adder_assert.svh.
//
// Channel   Direction  Beat contents
// s_axis    in         tdata = operand_a[31:0], operand_b[63:32]
// m_axis    out        tdata = sum_bits[31:0], signs_differ[32], exponent_overflow[33]
//
// Every beat passes four register stages; its result is offered from the last of them.
// One beat is accepted per cycle while the output side keeps taking results.
// A stalled stage holds its beat; empty stages upstream of it still fill.
// Reset clears only the stage valid bits.
`default_nettype none
module float32_magnitude_adder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // operand_a, operand_b
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // sum_bits, signs_differ, exponent_overflow
);
    import fma_pkg::*;
    `include "float32_magnitude_adder_assert.svh"

    logic [StageCount-1:0] valid_reg;
    logic [StageCount-1:0] valid_next;
    logic [StageCount-1:0] advance;
    logic [StageCount:0]   ready;
    result_t               result;

    always_comb
    begin
        ready[StageCount] = m_axis_tready;
        for (int i = StageCount - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        for (int i = 0; i < StageCount; i++)
        begin
            advance[i] = ready[i];
            if (i == 0)
                valid_next[i] = ready[i] ? s_axis_tvalid : valid_reg[i];
            else
                valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    fma_datapath u_datapath (
        .clk       (clk),
        .advance   (advance),
        .operand_a (s_axis_tdata[31:0]),
        .operand_b (s_axis_tdata[63:32]),
        .result    (result)
    );

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[StageCount-1];
    assign m_axis_tdata = {6'b0, result.exponent_overflow, result.signs_differ, result.sum_bits};

    `FMA_ASSERT_NEXT(a_hold_out, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `FMA_ASSERT_IMP(a_ovf_exp, clk, rst_n, m_axis_tvalid && m_axis_tdata[33] == 1'b0,
        m_axis_tdata[30:23] != 8'hFF)
    `FMA_ASSERT_NEXT(a_fill, clk, rst_n, s_axis_tvalid && s_axis_tready, valid_reg[0])
endmodule
`default_nettype wire
